// ----- rtl/core/llcp_pkg.sv -----
// shared widths, register codes and beat types of the line closest point block
package llcp_pkg;

   // field widths
   localparam int COORD_WIDTH    = 24;
   localparam int PARAM_WIDTH    = 32;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int DENOM_TOL_WIDTH = 32;
   localparam int COORD_TOL_WIDTH = COORD_WIDTH - 1;

   // datapath widths
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int MUL_WIDTH  = DIFF_WIDTH + COORD_WIDTH;
   localparam int DOT_WIDTH  = 2 * COORD_WIDTH + 3;
   localparam int SPLIT      = DOT_WIDTH / 2;
   localparam int HIGH       = DOT_WIDTH - SPLIT;
   localparam int PP_WIDTH   = 2 * HIGH + 2;
   localparam int PROD_WIDTH = 2 * DOT_WIDTH;
   localparam int NUM_WIDTH  = PROD_WIDTH + 1;
   localparam int REM_WIDTH  = NUM_WIDTH + PARAM_WIDTH + 1;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_COORD_TOL = 1'b0,
      CSR_DENOM_TOL = 1'b1
   } csr_index_type;

   // input beat: two lines
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] left_origin_x;
      logic signed [COORD_WIDTH-1:0] left_origin_y;
      logic signed [COORD_WIDTH-1:0] left_origin_z;
      logic signed [COORD_WIDTH-1:0] left_extent_x;
      logic signed [COORD_WIDTH-1:0] left_extent_y;
      logic signed [COORD_WIDTH-1:0] left_extent_z;
      logic signed [COORD_WIDTH-1:0] right_origin_x;
      logic signed [COORD_WIDTH-1:0] right_origin_y;
      logic signed [COORD_WIDTH-1:0] right_origin_z;
      logic signed [COORD_WIDTH-1:0] right_extent_x;
      logic signed [COORD_WIDTH-1:0] right_extent_y;
      logic signed [COORD_WIDTH-1:0] right_extent_z;
   } req_type;

   // result beat
   typedef struct packed {
      logic                          found;
      logic signed [PARAM_WIDTH-1:0] param_left;
      logic signed [PARAM_WIDTH-1:0] param_right;
      logic                          saturated;
   } rsp_type;

   // control flags that travel with an item through the divider
   typedef struct packed {
      logic fail;
      logic neg_l;
      logic neg_r;
      logic big_l;
      logic big_r;
   } flag_type;

endpackage

// ----- rtl/core/llcp_div_step.sv -----
// one restoring division step: compare against the shifted divisor and subtract
module llcp_div_step #(
   parameter int WIDTH     = llcp_pkg::REM_WIDTH,
   parameter int DEN_WIDTH = llcp_pkg::NUM_WIDTH,
   parameter int SHIFT     = 0
) (
   input  logic [WIDTH-1:0]     rem,
   input  logic [DEN_WIDTH-1:0] den,
   output logic [WIDTH-1:0]     rem_next,
   output logic                 quo_bit
);

   logic [WIDTH-1:0] den_shifted;

   // divisor aligned to this quotient bit
   assign den_shifted = WIDTH'(den) << SHIFT;
   assign quo_bit     = (rem >= den_shifted);
   assign rem_next    = quo_bit ? (rem - den_shifted) : rem;

endmodule

// ----- rtl/core/line_line_closest_point.sv -----
// top level of the closest point pipeline between two 3d lines
//
// Each beat carries two lines (origin and extent, signed Q12.12) and yields one result beat
// with the closest point parameters along both lines in signed Q16.16, clamped to range.
// A new pair is taken every cycle while req_stall is low. The restoring divider resolves one
// quotient bit per stage for both parameters and sits behind eight stages of differences, dot
// products, split 2x2 partial-product multiplies, the shared denominator and the tolerance
// checks; an output stage follows the divider. Stages that hold no item
// close up while the result side stalls, so input is still taken until the pipe is full.
// found is 0 (parameters 0) when either extent is within coord_tolerance in all three
// components or when the denominator magnitude is within denom_tolerance.
module line_line_closest_point (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  llcp_pkg::req_type                       req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output llcp_pkg::rsp_type                       rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  llcp_pkg::csr_index_type                 csr_index,
   input  logic [llcp_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   localparam int CW    = llcp_pkg::COORD_WIDTH;
   localparam int PW    = llcp_pkg::PARAM_WIDTH;
   localparam int DIFFW = llcp_pkg::DIFF_WIDTH;
   localparam int MULW  = llcp_pkg::MUL_WIDTH;
   localparam int DOTW  = llcp_pkg::DOT_WIDTH;
   localparam int SPL   = llcp_pkg::SPLIT;
   localparam int PPW   = llcp_pkg::PP_WIDTH;
   localparam int PRODW = llcp_pkg::PROD_WIDTH;
   localparam int NUMW  = llcp_pkg::NUM_WIDTH;
   localparam int REMW  = llcp_pkg::REM_WIDTH;

   // stage positions
   localparam int ST_IN   = 0;
   localparam int ST_MUL  = 1;
   localparam int ST_DOT  = 2;
   localparam int ST_PP   = 3;
   localparam int ST_PROD = 4;
   localparam int ST_DIFF = 5;
   localparam int ST_ABS  = 6;
   localparam int ST_INIT = 7;
   localparam int ST_DIV  = 8;
   localparam int ST_OUT  = ST_DIV + PW;
   localparam int NS      = ST_OUT + 1;

   // dot product slots
   localparam int DOT_WB = 0;
   localparam int DOT_BA = 1;
   localparam int DOT_WA = 2;
   localparam int DOT_BB = 3;
   localparam int DOT_AA = 4;

   localparam logic [PW-1:0] LIM_NEG = {1'b1, {(PW-1){1'b0}}};
   localparam logic [PW-1:0] LIM_POS = {1'b0, {(PW-1){1'b1}}};

   // configuration
   logic [llcp_pkg::COORD_TOL_WIDTH-1:0] coord_tol_ff;
   logic [llcp_pkg::DENOM_TOL_WIDTH-1:0] denom_tol_ff;

   // flow control
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] load;

   // stage registers
   logic signed [DIFFW-1:0] s0_w_ff [3];
   logic signed [DIFFW-1:0] s0_w_in [3];
   logic signed [CW-1:0]    s0_a_ff [3];
   logic signed [CW-1:0]    s0_a_in [3];
   logic signed [CW-1:0]    s0_b_ff [3];
   logic signed [CW-1:0]    s0_b_in [3];
   logic                    s0_degen_ff, s0_degen_in;

   logic signed [MULW-1:0]  s1_p_ff [5][3];
   logic signed [MULW-1:0]  s1_p_in [5][3];
   logic                    s1_degen_ff;

   logic signed [DOTW-1:0]  s2_dot_ff [5];
   logic signed [DOTW-1:0]  s2_dot_in [5];
   logic                    s2_degen_ff;

   logic signed [DOTW-1:0]  opx [6];
   logic signed [DOTW-1:0]  opy [6];
   logic signed [PPW-1:0]   s3_pp_ff [6][4];
   logic signed [PPW-1:0]   s3_pp_in [6][4];
   logic                    s3_degen_ff;

   logic signed [PRODW-1:0] s4_prod_ff [6];
   logic signed [PRODW-1:0] s4_prod_in [6];
   logic                    s4_degen_ff;

   logic signed [NUMW-1:0]  s5_den_ff, s5_den_in;
   logic signed [NUMW-1:0]  s5_numl_ff, s5_numl_in;
   logic signed [NUMW-1:0]  s5_numr_ff, s5_numr_in;
   logic                    s5_degen_ff;

   logic [NUMW-1:0]         s6_den_ff, s6_den_in;
   logic [NUMW-1:0]         s6_numl_ff, s6_numl_in;
   logic [NUMW-1:0]         s6_numr_ff, s6_numr_in;
   logic                    s6_neg_l_ff, s6_neg_l_in;
   logic                    s6_neg_r_ff, s6_neg_r_in;
   logic                    s6_degen_ff;

   logic [REMW-1:0]          s7_rem_l_ff, s7_rem_l_in;
   logic [REMW-1:0]          s7_rem_r_ff, s7_rem_r_in;
   logic [NUMW-1:0]          s7_den_ff;
   llcp_pkg::flag_type       s7_flags_ff, s7_flags_in;

   logic [REMW-1:0]          div_rem_l_ff [PW];
   logic [REMW-1:0]          div_rem_l_in [PW];
   logic [REMW-1:0]          div_rem_r_ff [PW];
   logic [REMW-1:0]          div_rem_r_in [PW];
   logic [NUMW-1:0]          div_den_ff   [PW];
   logic [NUMW-1:0]          div_den_in   [PW];
   logic [PW-1:0]            div_ql_ff    [PW];
   logic [PW-1:0]            div_ql_in    [PW];
   logic [PW-1:0]            div_qr_ff    [PW];
   logic [PW-1:0]            div_qr_in    [PW];
   llcp_pkg::flag_type       div_flags_ff [PW];
   llcp_pkg::flag_type       div_flags_in [PW];
   logic [PW-1:0]            bit_l, bit_r;

   llcp_pkg::rsp_type        out_ff, out_in;
   logic [PW:0]              clamp_l, clamp_r;

   function automatic logic near_zero(input logic signed [CW-1:0] x,
                                      input logic [llcp_pkg::COORD_TOL_WIDTH-1:0] tol);
      logic [CW-1:0] mag;
      mag = x[CW-1] ? (~x + 1'b1) : x;
      return mag <= {1'b0, tol};
   endfunction

   function automatic logic [NUMW-1:0] magnitude(input logic signed [NUMW-1:0] x);
      return x[NUMW-1] ? (~x + 1'b1) : x;
   endfunction

   // {saturated, value} from a quotient magnitude and sign
   function automatic logic [PW:0] clamp_param(input logic [PW-1:0] mag, input logic neg,
                                               input logic big);
      logic          sat;
      logic [PW-1:0] val;
      if (neg) begin
         sat = big || (mag > LIM_NEG);
         val = sat ? LIM_NEG : (~mag + 1'b1);
      end else begin
         sat = big || (mag > LIM_POS);
         val = sat ? LIM_POS : mag;
      end
      return {sat, val};
   endfunction

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_tol_ff <= '0;
         denom_tol_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            llcp_pkg::CSR_COORD_TOL: coord_tol_ff <= csr_data[llcp_pkg::COORD_TOL_WIDTH-1:0];
            llcp_pkg::CSR_DENOM_TOL: denom_tol_ff <= csr_data[llcp_pkg::DENOM_TOL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // a stage loads when it is empty or its item moves on
   always_comb begin
      load[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int i = NS - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
   end

   assign req_stall = !load[ST_IN];
   assign rsp_valid = valid_ff[ST_OUT];
   assign rsp_data  = out_ff;

   // each stage takes the valid bit of the stage before it
   assign valid_in = {valid_ff[NS-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (load[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // stage 0: difference of origins and degenerate extent check
   always_comb begin
      s0_w_in[0] = DIFFW'($signed(req_data.left_origin_x)) - DIFFW'($signed(req_data.right_origin_x));
      s0_w_in[1] = DIFFW'($signed(req_data.left_origin_y)) - DIFFW'($signed(req_data.right_origin_y));
      s0_w_in[2] = DIFFW'($signed(req_data.left_origin_z)) - DIFFW'($signed(req_data.right_origin_z));
      s0_a_in[0] = req_data.left_extent_x;
      s0_a_in[1] = req_data.left_extent_y;
      s0_a_in[2] = req_data.left_extent_z;
      s0_b_in[0] = req_data.right_extent_x;
      s0_b_in[1] = req_data.right_extent_y;
      s0_b_in[2] = req_data.right_extent_z;
      s0_degen_in = (near_zero(s0_a_in[0], coord_tol_ff) && near_zero(s0_a_in[1], coord_tol_ff)
                     && near_zero(s0_a_in[2], coord_tol_ff))
                 || (near_zero(s0_b_in[0], coord_tol_ff) && near_zero(s0_b_in[1], coord_tol_ff)
                     && near_zero(s0_b_in[2], coord_tol_ff));
   end

   // stage 1: component products of the five dot products
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_p_in[DOT_WB][i] = MULW'(s0_w_ff[i]) * MULW'(s0_b_ff[i]);
         s1_p_in[DOT_BA][i] = MULW'(s0_b_ff[i]) * MULW'(s0_a_ff[i]);
         s1_p_in[DOT_WA][i] = MULW'(s0_w_ff[i]) * MULW'(s0_a_ff[i]);
         s1_p_in[DOT_BB][i] = MULW'(s0_b_ff[i]) * MULW'(s0_b_ff[i]);
         s1_p_in[DOT_AA][i] = MULW'(s0_a_ff[i]) * MULW'(s0_a_ff[i]);
      end
   end

   // stage 2: dot product sums
   always_comb begin
      for (int d = 0; d < 5; d++) begin
         s2_dot_in[d] = DOTW'(s1_p_ff[d][0]) + DOTW'(s1_p_ff[d][1]) + DOTW'(s1_p_ff[d][2]);
      end
   end

   // stage 3: operands of the six wide products, split into halves
   always_comb begin
      opx[0] = s2_dot_ff[DOT_AA]; opy[0] = s2_dot_ff[DOT_BB];
      opx[1] = s2_dot_ff[DOT_BA]; opy[1] = s2_dot_ff[DOT_BA];
      opx[2] = s2_dot_ff[DOT_WB]; opy[2] = s2_dot_ff[DOT_BA];
      opx[3] = s2_dot_ff[DOT_WA]; opy[3] = s2_dot_ff[DOT_BB];
      opx[4] = s2_dot_ff[DOT_WB]; opy[4] = s2_dot_ff[DOT_AA];
      opx[5] = s2_dot_ff[DOT_WA]; opy[5] = s2_dot_ff[DOT_BA];
   end

   always_comb begin
      logic signed [PPW-1:0] xh, xl, yh, yl;
      for (int j = 0; j < 6; j++) begin
         xh = PPW'($signed(opx[j][DOTW-1:SPL]));
         xl = PPW'($signed({1'b0, opx[j][SPL-1:0]}));
         yh = PPW'($signed(opy[j][DOTW-1:SPL]));
         yl = PPW'($signed({1'b0, opy[j][SPL-1:0]}));
         s3_pp_in[j][0] = xh * yh;
         s3_pp_in[j][1] = xh * yl;
         s3_pp_in[j][2] = xl * yh;
         s3_pp_in[j][3] = xl * yl;
      end
   end

   // stage 4: recombine partial products
   always_comb begin
      for (int j = 0; j < 6; j++) begin
         s4_prod_in[j] = (PRODW'(s3_pp_ff[j][0]) <<< (2 * SPL))
                       + ((PRODW'(s3_pp_ff[j][1]) + PRODW'(s3_pp_ff[j][2])) <<< SPL)
                       + PRODW'(s3_pp_ff[j][3]);
      end
   end

   // stage 5: denominator and both numerators
   assign s5_den_in  = NUMW'(s4_prod_ff[0]) - NUMW'(s4_prod_ff[1]);
   assign s5_numl_in = NUMW'(s4_prod_ff[2]) - NUMW'(s4_prod_ff[3]);
   assign s5_numr_in = NUMW'(s4_prod_ff[4]) - NUMW'(s4_prod_ff[5]);

   // stage 6: magnitudes and result signs
   assign s6_den_in   = magnitude(s5_den_ff);
   assign s6_numl_in  = magnitude(s5_numl_ff);
   assign s6_numr_in  = magnitude(s5_numr_ff);
   assign s6_neg_l_in = s5_numl_ff[NUMW-1] ^ s5_den_ff[NUMW-1];
   assign s6_neg_r_in = s5_numr_ff[NUMW-1] ^ s5_den_ff[NUMW-1];

   // stage 7: parallel check, scaled dividends and quotient range check
   always_comb begin
      s7_rem_l_in       = REMW'(s6_numl_ff) << llcp_pkg::FRAC_BITS;
      s7_rem_r_in       = REMW'(s6_numr_ff) << llcp_pkg::FRAC_BITS;
      s7_flags_in.fail  = s6_degen_ff || (s6_den_ff <= NUMW'(denom_tol_ff));
      s7_flags_in.neg_l = s6_neg_l_ff;
      s7_flags_in.neg_r = s6_neg_r_ff;
      s7_flags_in.big_l = s7_rem_l_in >= (REMW'(s6_den_ff) << PW);
      s7_flags_in.big_r = s7_rem_r_in >= (REMW'(s6_den_ff) << PW);
   end

   // divider: one quotient bit per stage, most significant first
   for (genvar k = 0; k < PW; k++) begin : g_div
      logic [REMW-1:0] src_rem_l, src_rem_r;
      logic [NUMW-1:0] src_den;
      if (k == 0) begin : g_first
         assign src_rem_l = s7_rem_l_ff;
         assign src_rem_r = s7_rem_r_ff;
         assign src_den   = s7_den_ff;
         assign div_flags_in[k] = s7_flags_ff;
         assign div_ql_in[k] = PW'(bit_l[k]);
         assign div_qr_in[k] = PW'(bit_r[k]);
      end else begin : g_next
         assign src_rem_l = div_rem_l_ff[k-1];
         assign src_rem_r = div_rem_r_ff[k-1];
         assign src_den   = div_den_ff[k-1];
         assign div_flags_in[k] = div_flags_ff[k-1];
         assign div_ql_in[k] = {div_ql_ff[k-1][PW-2:0], bit_l[k]};
         assign div_qr_in[k] = {div_qr_ff[k-1][PW-2:0], bit_r[k]};
      end
      assign div_den_in[k] = src_den;

      llcp_div_step #(.WIDTH(REMW), .DEN_WIDTH(NUMW), .SHIFT(PW - 1 - k)) u_step_l (
         .rem      (src_rem_l),
         .den      (src_den),
         .rem_next (div_rem_l_in[k]),
         .quo_bit  (bit_l[k])
      );

      llcp_div_step #(.WIDTH(REMW), .DEN_WIDTH(NUMW), .SHIFT(PW - 1 - k)) u_step_r (
         .rem      (src_rem_r),
         .den      (src_den),
         .rem_next (div_rem_r_in[k]),
         .quo_bit  (bit_r[k])
      );
   end

   // output stage: sign, clamp and failure masking
   always_comb begin
      clamp_l = clamp_param(div_ql_ff[PW-1], div_flags_ff[PW-1].neg_l, div_flags_ff[PW-1].big_l);
      clamp_r = clamp_param(div_qr_ff[PW-1], div_flags_ff[PW-1].neg_r, div_flags_ff[PW-1].big_r);
      if (div_flags_ff[PW-1].fail) begin
         out_in.found       = 1'b0;
         out_in.param_left  = '0;
         out_in.param_right = '0;
         out_in.saturated   = 1'b0;
      end else begin
         out_in.found       = 1'b1;
         out_in.param_left  = $signed(clamp_l[PW-1:0]);
         out_in.param_right = $signed(clamp_r[PW-1:0]);
         out_in.saturated   = clamp_l[PW] || clamp_r[PW];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load[ST_IN]) begin
         for (int i = 0; i < 3; i++) begin
            s0_w_ff[i] <= s0_w_in[i];
            s0_a_ff[i] <= s0_a_in[i];
            s0_b_ff[i] <= s0_b_in[i];
         end
         s0_degen_ff <= s0_degen_in;
      end
      if (load[ST_MUL]) begin
         s1_p_ff     <= s1_p_in;
         s1_degen_ff <= s0_degen_ff;
      end
      if (load[ST_DOT]) begin
         s2_dot_ff   <= s2_dot_in;
         s2_degen_ff <= s1_degen_ff;
      end
      if (load[ST_PP]) begin
         s3_pp_ff    <= s3_pp_in;
         s3_degen_ff <= s2_degen_ff;
      end
      if (load[ST_PROD]) begin
         s4_prod_ff  <= s4_prod_in;
         s4_degen_ff <= s3_degen_ff;
      end
      if (load[ST_DIFF]) begin
         s5_den_ff   <= s5_den_in;
         s5_numl_ff  <= s5_numl_in;
         s5_numr_ff  <= s5_numr_in;
         s5_degen_ff <= s4_degen_ff;
      end
      if (load[ST_ABS]) begin
         s6_den_ff   <= s6_den_in;
         s6_numl_ff  <= s6_numl_in;
         s6_numr_ff  <= s6_numr_in;
         s6_neg_l_ff <= s6_neg_l_in;
         s6_neg_r_ff <= s6_neg_r_in;
         s6_degen_ff <= s5_degen_ff;
      end
      if (load[ST_INIT]) begin
         s7_rem_l_ff <= s7_rem_l_in;
         s7_rem_r_ff <= s7_rem_r_in;
         s7_den_ff   <= s6_den_ff;
         s7_flags_ff <= s7_flags_in;
      end
      for (int k = 0; k < PW; k++) begin
         if (load[ST_DIV + k]) begin
            div_rem_l_ff[k] <= div_rem_l_in[k];
            div_rem_r_ff[k] <= div_rem_r_in[k];
            div_ql_ff[k]    <= div_ql_in[k];
            div_qr_ff[k]    <= div_qr_in[k];
            div_den_ff[k]   <= div_den_in[k];
            div_flags_ff[k] <= div_flags_in[k];
         end
      end
      if (load[ST_OUT]) begin
         out_ff <= out_in;
      end
   end

   // checks
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[ST_IN])
      else $error("accepted beat did not enter the first stage");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.param_left == '0 && rsp_data.param_right == '0 && !rsp_data.saturated)
      else $error("result without closest points carries nonzero fields");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         $unsigned(rsp_data.param_left) == LIM_POS || $unsigned(rsp_data.param_left) == LIM_NEG
         || $unsigned(rsp_data.param_right) == LIM_POS
         || $unsigned(rsp_data.param_right) == LIM_NEG)
      else $error("saturated result has no parameter at a range limit");

   a_stall_bubble: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[ST_OUT] |-> !req_stall)
      else $error("input stalled although the pipe has room");

endmodule
